/* hdl/polynomial_bisection_root_assert.svh */
// assertion macros for the polynomial bisection root finder
// expects clk and rst_n in the scope where a macro is used
`ifndef POLYNOMIAL_BISECTION_ROOT_ASSERT_SVH
`define POLYNOMIAL_BISECTION_ROOT_ASSERT_SVH

// same-cycle implication
`define PBR_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PBR_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// implication after a fixed number of cycles
`define PBR_ASSERT_DLY(name, ante, dly, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
    else $error(msg);

`endif

/* hdl/pbr_pkg.sv */
// shared types, widths and codes of the polynomial bisection root finder
// no dependencies
package pbr_pkg;

  localparam int COEFF_COUNT = 6;
  localparam int FRAC_BITS   = 16;
  localparam int VAL_W       = 32;                  // endpoints and coefficients
  localparam int POLY_W      = 48;                  // saturated sum and power
  localparam int PROD_W      = VAL_W + POLY_W;      // exact product
  localparam int SHR_W       = PROD_W - FRAC_BITS;  // product after the fraction shift
  localparam int LO_W        = POLY_W / 2;          // low slice of the power operand
  localparam int HI_W        = POLY_W - LO_W;       // high slice of the power operand
  localparam int CIDX_W      = $clog2(COEFF_COUNT);
  localparam int TOL_W       = 16;
  localparam int ITER_W      = 8;
  localparam int STAT_W      = 2;
  localparam int CFG_IDX_W   = 3;
  localparam int MAC_LAT     = 3;                   // start to done of the multiply unit

  localparam logic signed [POLY_W-1:0] ONE_FIX = POLY_W'(1) << FRAC_BITS;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COEF_FIRST = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_LAST  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER   = 3'd7;

  // result status codes
  localparam logic [STAT_W-1:0] ST_CONVERGED  = 2'd0;
  localparam logic [STAT_W-1:0] ST_SIGN_ERR   = 2'd1;
  localparam logic [STAT_W-1:0] ST_ITER_LIMIT = 2'd2;

  typedef struct packed {
    logic signed [VAL_W-1:0] start_a;
    logic signed [VAL_W-1:0] start_b;
  } pbr_in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] end_a;
    logic signed [VAL_W-1:0] end_b;
    logic signed [VAL_W-1:0] root_estimate;
    logic [STAT_W-1:0]       status;
    logic [ITER_W-1:0]       iterations_used;
  } pbr_out_t;

  // request to the shared multiply unit
  typedef struct packed {
    logic                     start;
    logic signed [VAL_W-1:0]  a;
    logic signed [POLY_W-1:0] b;
  } pbr_mac_req_t;

  // response of the shared multiply unit
  typedef struct packed {
    logic                    busy;
    logic                    done;
    logic signed [SHR_W-1:0] prod;
  } pbr_mac_rsp_t;

endpackage

/* hdl/polynomial_bisection_root.sv */
// polynomial bisection root finder, top level; depends on pbr_pkg and pbr_mac
// sequence: 11 multiplies per polynomial evaluation (6 terms, 5 powers); each iteration
//   evaluates a, b and the midpoint c; a sign error ends the run after a and b are
//   evaluated, the iteration limit before any evaluation
// throughput: one request at a time, next one accepted the cycle after the result is
//   registered; set by the sequencer, which shares the single multiply unit and takes requests only in S_IDLE
// reset: synchronous active-low, coefficients 0, tolerance 2, iteration limit 100
`include "polynomial_bisection_root_assert.svh"
module polynomial_bisection_root (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // request channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  pbr_pkg::pbr_in_t                     in_data,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output pbr_pkg::pbr_out_t                    out_data,
  // configuration writes
  input  logic                                 cfg_we,
  input  logic [pbr_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [pbr_pkg::VAL_W-1:0]            cfg_wdata
);
  import pbr_pkg::*;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,       // waiting for a request
    S_CHECK,      // iteration limit test
    S_TERM_GO,    // launch coef_i * power
    S_TERM_WAIT,  // accumulate the term
    S_POW_GO,     // launch power * x
    S_POW_WAIT,   // update the power
    S_EVAL_END,   // act on a finished evaluation
    S_CONV,       // interval width test
    S_DONE        // hand the result to the output register
  } state_t;

  // which point the current evaluation is for
  typedef enum logic [1:0] {TGT_A, TGT_B, TGT_C} tgt_t;

  // configuration registers
  logic signed [VAL_W-1:0] coef_r [COEFF_COUNT];
  logic [TOL_W-1:0]        tol_r;
  logic [ITER_W-1:0]       max_iter_r;

  // sequencer and datapath registers
  state_t                   state_r;
  tgt_t                     tgt_r;
  logic [CIDX_W-1:0]        idx_r;
  logic [ITER_W-1:0]        iter_r;
  logic [STAT_W-1:0]        status_r;
  logic signed [VAL_W-1:0]  a_r;
  logic signed [VAL_W-1:0]  b_r;
  logic signed [VAL_W-1:0]  c_r;
  logic signed [POLY_W-1:0] sum_r;
  logic signed [POLY_W-1:0] power_r;
  logic                     fa_pos_r;
  logic                     fa_neg_r;
  logic                     out_valid_r;
  pbr_out_t                 out_data_r;

  pbr_mac_req_t mac_req;
  pbr_mac_rsp_t mac_rsp;

  logic signed [VAL_W-1:0]  x_sel;
  logic signed [VAL_W:0]    ab_sum;
  logic signed [VAL_W-1:0]  mid_nxt;
  logic signed [VAL_W:0]    ab_diff;
  logic [VAL_W:0]           ab_dist;
  logic signed [SHR_W:0]    term_sum;
  logic signed [POLY_W-1:0] sum_nxt;
  logic signed [POLY_W-1:0] power_nxt;
  logic                     f_pos;
  logic                     f_neg;

  // clamp a widened value to the 48-bit polynomial range
  function automatic logic signed [POLY_W-1:0] sat_poly(input logic signed [SHR_W:0] v);
    logic hi_ones;
    logic hi_zeros;
    hi_ones  = &v[SHR_W:POLY_W-1];
    hi_zeros = ~|v[SHR_W:POLY_W-1];
    if (hi_ones || hi_zeros) begin
      return v[POLY_W-1:0];
    end else if (v[SHR_W]) begin
      return {1'b1, {(POLY_W-1){1'b0}}};
    end else begin
      return {1'b0, {(POLY_W-1){1'b1}}};
    end
  endfunction

  // configuration decode
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < COEFF_COUNT; i++) begin
        coef_r[i] <= '0;
      end
      tol_r      <= TOL_W'(2);
      max_iter_r <= ITER_W'(100);
    end else if (cfg_we) begin
      unique case (cfg_index) inside
        [REG_COEF_FIRST:REG_COEF_LAST]: coef_r[cfg_index[CIDX_W-1:0]] <= cfg_wdata;
        REG_TOLERANCE:                  tol_r      <= cfg_wdata[TOL_W-1:0];
        REG_MAX_ITER:                   max_iter_r <= cfg_wdata[ITER_W-1:0];
        default: ;
      endcase
    end
  end

  // point under evaluation, midpoint and interval width
  always_comb begin
    case (tgt_r)
      TGT_A:   x_sel = a_r;
      TGT_B:   x_sel = b_r;
      default: x_sel = c_r;
    endcase
    ab_sum   = {a_r[VAL_W-1], a_r} + {b_r[VAL_W-1], b_r};
    mid_nxt  = ab_sum[VAL_W:1];                  // floor of half the sum
    ab_diff  = {a_r[VAL_W-1], a_r} - {b_r[VAL_W-1], b_r};
    ab_dist  = ab_diff[VAL_W] ? -ab_diff : ab_diff;
    term_sum = {{(SHR_W+1-POLY_W){sum_r[POLY_W-1]}}, sum_r}
             + {mac_rsp.prod[SHR_W-1], mac_rsp.prod};
    sum_nxt   = sat_poly(term_sum);
    power_nxt = sat_poly({mac_rsp.prod[SHR_W-1], mac_rsp.prod});
    f_pos     = (sum_r > 0);
    f_neg     = sum_r[POLY_W-1];
  end

  // the one multiplier: coefficient times power, or power times x
  assign mac_req.start = (state_r == S_TERM_GO) || (state_r == S_POW_GO);
  assign mac_req.a     = (state_r == S_TERM_GO) ? coef_r[idx_r] : x_sel;
  assign mac_req.b     = power_r;

  pbr_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mac_req),
    .rsp   (mac_rsp)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      tgt_r       <= TGT_A;
      idx_r       <= '0;
      iter_r      <= '0;
    end else begin
      // drained result; a new one loaded in S_DONE takes its place instead
      if (out_valid_r && !out_stall && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            a_r     <= in_data.start_a;
            b_r     <= in_data.start_b;
            iter_r  <= '0;
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (iter_r < max_iter_r) begin
            tgt_r   <= TGT_A;
            idx_r   <= '0;
            sum_r   <= '0;
            power_r <= ONE_FIX;
            state_r <= S_TERM_GO;
          end else begin
            status_r <= ST_ITER_LIMIT;
            state_r  <= S_DONE;
          end
        end
        S_TERM_GO: state_r <= S_TERM_WAIT;
        S_TERM_WAIT: begin
          if (mac_rsp.done) begin
            sum_r <= sum_nxt;
            // the last power is never needed
            if (idx_r == CIDX_W'(COEFF_COUNT - 1)) begin
              state_r <= S_EVAL_END;
            end else begin
              state_r <= S_POW_GO;
            end
          end
        end
        S_POW_GO: state_r <= S_POW_WAIT;
        S_POW_WAIT: begin
          if (mac_rsp.done) begin
            power_r <= power_nxt;
            idx_r   <= idx_r + 1'b1;
            state_r <= S_TERM_GO;
          end
        end
        S_EVAL_END: begin
          idx_r   <= '0;
          power_r <= ONE_FIX;
          unique case (tgt_r)
            TGT_A: begin
              fa_pos_r <= f_pos;
              fa_neg_r <= f_neg;
              sum_r    <= '0;
              tgt_r    <= TGT_B;
              state_r  <= S_TERM_GO;
            end
            TGT_B: begin
              // both ends strictly on the same side of zero
              if ((fa_pos_r && f_pos) || (fa_neg_r && f_neg)) begin
                status_r <= ST_SIGN_ERR;
                state_r  <= S_DONE;
              end else begin
                c_r     <= mid_nxt;
                sum_r   <= '0;
                tgt_r   <= TGT_C;
                state_r <= S_TERM_GO;
              end
            end
            default: begin
              // sign change between a and c: keep the half from a to c
              if ((fa_pos_r && f_neg) || (fa_neg_r && f_pos)) begin
                b_r <= c_r;
              end else begin
                a_r <= c_r;
              end
              iter_r  <= iter_r + 1'b1;
              state_r <= S_CONV;
            end
          endcase
        end
        S_CONV: begin
          if (ab_dist < {{(VAL_W+1-TOL_W){1'b0}}, tol_r}) begin
            status_r <= ST_CONVERGED;
            state_r  <= S_DONE;
          end else begin
            state_r <= S_CHECK;
          end
        end
        S_DONE: begin
          // output register free or being drained this cycle
          if (!out_valid_r || !out_stall) begin
            out_data_r.end_a           <= a_r;
            out_data_r.end_b           <= b_r;
            out_data_r.root_estimate   <= mid_nxt;
            out_data_r.status          <= status_r;
            out_data_r.iterations_used <= iter_r;
            out_valid_r                <= 1'b1;
            state_r                    <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // multiply unit is only launched when free
  `PBR_ASSERT_IMP(a_mac_free, mac_req.start, !mac_rsp.busy, "multiply launched while busy")
  // multiply result arrives a fixed time after launch
  `PBR_ASSERT_DLY(a_mac_lat, mac_req.start, MAC_LAT, mac_rsp.done, "multiply result late")
  // an accepted request always starts the sequencer
  `PBR_ASSERT_NXT(a_req_start, in_valid && !in_stall, state_r == S_CHECK, "request not started")

endmodule

/* hdl/pbr_mac.sv */
// shared multiply unit: floor(a * b / 2^FRAC_BITS), exact, in two partial products
// depends on pbr_pkg
module pbr_mac (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pbr_pkg::pbr_mac_req_t req,
  output pbr_pkg::pbr_mac_rsp_t rsp
);
  import pbr_pkg::*;

  localparam int PART_W = VAL_W + LO_W + 1;
  localparam int HIP_W  = VAL_W + HI_W;

  typedef enum logic [1:0] {P_IDLE, P_HI, P_ADD} phase_t;

  phase_t                   phase_r;
  logic                     done_r;
  logic signed [VAL_W-1:0]  a_r;
  logic signed [HI_W-1:0]   bh_r;
  logic signed [PART_W-1:0] prod_r;
  logic signed [PROD_W-1:0] acc_r;

  logic signed [LO_W:0]     b_lo;
  logic signed [PART_W-1:0] prod_lo;
  logic signed [PART_W-1:0] prod_hi;
  logic signed [PROD_W-1:0] hi_shift;

  always_comb begin
    b_lo     = $signed({1'b0, req.b[LO_W-1:0]});
    prod_lo  = req.a * b_lo;
    prod_hi  = a_r * bh_r;
    hi_shift = $signed({prod_r[HIP_W-1:0], {LO_W{1'b0}}});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= P_IDLE;
      done_r  <= 1'b0;
    end else begin
      unique case (phase_r)
        P_IDLE: begin
          done_r <= 1'b0;
          if (req.start) begin
            prod_r  <= prod_lo;
            a_r     <= req.a;
            bh_r    <= req.b[POLY_W-1:LO_W];
            phase_r <= P_HI;
          end
        end
        P_HI: begin
          acc_r   <= {{(PROD_W-PART_W){prod_r[PART_W-1]}}, prod_r};
          prod_r  <= prod_hi;
          phase_r <= P_ADD;
        end
        P_ADD: begin
          acc_r   <= acc_r + hi_shift;
          done_r  <= 1'b1;
          phase_r <= P_IDLE;
        end
        default: phase_r <= P_IDLE;
      endcase
    end
  end

  assign rsp.busy = (phase_r != P_IDLE);
  assign rsp.done = done_r;
  assign rsp.prod = acc_r[FRAC_BITS +: SHR_W];

endmodule

/* sim/polynomial_bisection_root_tb.sv */
`timescale 1ns / 100ps
// self-checking bench for polynomial_bisection_root: bisection requests under random pacing,
// each result checked against an in-bench fixed-point bisection predictor
// depends on pbr_pkg and the polynomial_bisection_root rtl
module polynomial_bisection_root_tb;
  import pbr_pkg::*;

  // wide enough for every exact product of the evaluation
  typedef logic signed [127:0] wide_t;

  // coefficient families for the random part
  typedef enum int {POLY_MODERATE, POLY_FULL_RANGE, POLY_KNOWN_ROOT} poly_style_t;

  localparam wide_t SUM_MAX  = (wide_t'(1) <<< (POLY_W - 1)) - 1;
  localparam wide_t SUM_MIN  = -(wide_t'(1) <<< (POLY_W - 1));
  localparam wide_t PROD_CAP = wide_t'(1) <<< 62;
  localparam wide_t ONE_Q    = wide_t'(1) <<< FRAC_BITS;

  localparam logic [TOL_W-1:0]  RESET_TOL   = TOL_W'(2);
  localparam logic [ITER_W-1:0] RESET_LIMIT = ITER_W'(100);

  localparam logic [VAL_W-1:0] Q_MAX = 32'h7fff_ffff;
  localparam logic [VAL_W-1:0] Q_MIN = 32'h8000_0000;

  localparam int RAND_PHASES = 6;
  localparam int PHASE_REQS  = 37;
  localparam int TAIL_CYCLES = 300;
  // slowest correct run: every request at its iteration limit, about 14.5k
  // iterations, plus sender gaps and receiver stalls
  localparam int unsigned RUN_LIMIT = 8_000_000;

  // clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // request channel
  logic    in_valid = 1'b0;
  logic    in_stall;
  pbr_in_t in_data  = '0;

  // result channel
  logic     out_valid;
  logic     out_stall = 1'b0;
  pbr_out_t out_data;

  // register write port
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [VAL_W-1:0]     cfg_wdata = '0;

  // bench copy of the block's registers
  logic signed [VAL_W-1:0] coef_shadow [COEFF_COUNT];
  logic [TOL_W-1:0]        tol_shadow        = RESET_TOL;
  logic [ITER_W-1:0]       iter_limit_shadow = RESET_LIMIT;

  // requests waiting for the driver, results waiting for the block
  pbr_in_t  pending_reqs[$];
  pbr_out_t expected_roots[$];

  int unsigned sent_count    = 0;
  int unsigned checked_count = 0;
  int unsigned fault_count   = 0;
  int unsigned config_count  = 1;
  int unsigned conv_seen     = 0;
  int unsigned sign_err_seen = 0;
  int unsigned limit_seen    = 0;
  int unsigned cycle_count   = 0;

  polynomial_bisection_root uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // clamp to the 48-bit range of the sum and power registers
  function automatic wide_t clip48(wide_t v);
    if (v > SUM_MAX) return SUM_MAX;
    if (v < SUM_MIN) return SUM_MIN;
    return v;
  endfunction

  // exact product, floor shift by the fraction width, clamped to +-2^62
  function automatic wide_t scaled_product(wide_t x, wide_t y);
    wide_t p;
    p = (x * y) >>> FRAC_BITS;
    if (p > PROD_CAP) return PROD_CAP;
    if (p < -PROD_CAP) return -PROD_CAP;
    return p;
  endfunction

  // ascending powers: term first, then the next power
  function automatic wide_t poly_value(logic signed [VAL_W-1:0] x);
    wide_t acc, pw;
    acc = '0;
    pw  = ONE_Q;
    for (int i = 0; i < COEFF_COUNT; i++) begin
      acc = clip48(acc + scaled_product(coef_shadow[i], pw));
      pw  = clip48(scaled_product(pw, x));
    end
    return acc;
  endfunction

  // a zero on either side never counts as the same sign
  function automatic logic same_sign(wide_t p, wide_t q);
    return (p > 0 && q > 0) || (p < 0 && q < 0);
  endfunction

  // full bisection run for one request under the current registers
  function automatic pbr_out_t bisect_predict(pbr_in_t req);
    wide_t             lo, hi, mid, fa, fc, span;
    int unsigned       steps;
    logic [STAT_W-1:0] outcome;
    logic              settled;
    pbr_out_t          res;
    lo      = $signed(req.start_a);
    hi      = $signed(req.start_b);
    steps   = 0;
    outcome = ST_ITER_LIMIT;
    settled = 1'b0;
    while (!settled && steps < iter_limit_shadow) begin
      fa = poly_value(lo[VAL_W-1:0]);
      if (same_sign(fa, poly_value(hi[VAL_W-1:0]))) begin
        // endpoints stay as they were at the start of this iteration
        outcome = ST_SIGN_ERR;
        settled = 1'b1;
      end else begin
        mid = (lo + hi) >>> 1;
        fc  = poly_value(mid[VAL_W-1:0]);
        // a zero at the midpoint moves the first endpoint
        if ((fa > 0 && fc < 0) || (fa < 0 && fc > 0)) hi = mid;
        else lo = mid;
        steps++;
        span = (lo > hi) ? lo - hi : hi - lo;
        if (span < wide_t'(tol_shadow)) begin
          outcome = ST_CONVERGED;
          settled = 1'b1;
        end
      end
    end
    mid                 = (lo + hi) >>> 1;
    res.end_a           = lo[VAL_W-1:0];
    res.end_b           = hi[VAL_W-1:0];
    res.root_estimate   = mid[VAL_W-1:0];
    res.status          = outcome;
    res.iterations_used = steps[ITER_W-1:0];
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // helpers for the stimulus
  // ---------------------------------------------------------------------------

  function automatic void note_fault(string msg);
    if (fault_count < 10) $display("[%0t] mismatch: %s", $realtime, msg);
    fault_count++;
  endfunction

  function automatic void queue_req(logic [VAL_W-1:0] a, logic [VAL_W-1:0] b);
    pbr_in_t req;
    req.start_a = a;
    req.start_b = b;
    pending_reqs.push_back(req);
  endfunction

  // idle means: nothing queued, nothing offered, nothing outstanding
  task automatic drain_all();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || in_valid || expected_roots.size() != 0);
  endtask

  // one register write; the shadow follows once the write edge has passed
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VAL_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx <= REG_COEF_LAST) coef_shadow[idx - REG_COEF_FIRST] = data;
    else if (idx == REG_TOLERANCE) tol_shadow = data[TOL_W-1:0];
    else iter_limit_shadow = data[ITER_W-1:0];
  endtask

  // waits for the block to go idle, then rewrites every register
  task automatic load_setting(input logic [VAL_W-1:0] c0, c1, c2, c3, c4, c5,
                              input logic [TOL_W-1:0] tol, input logic [ITER_W-1:0] lim);
    logic [VAL_W-1:0] coefs [COEFF_COUNT];
    drain_all();
    coefs[0] = c0;
    coefs[1] = c1;
    coefs[2] = c2;
    coefs[3] = c3;
    coefs[4] = c4;
    coefs[5] = c5;
    for (int i = 0; i < COEFF_COUNT; i++)
      write_reg(REG_COEF_FIRST + CFG_IDX_W'(i), coefs[i]);
    write_reg(REG_TOLERANCE, VAL_W'(tol));
    write_reg(REG_MAX_ITER, VAL_W'(lim));
    config_count++;
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // request driver: bursts of random length, random gaps between them
  // ---------------------------------------------------------------------------
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(posedge clk) begin : drive_reqs
    logic accepted;
    logic next_valid;
    if (!rst_n) begin
      in_valid   <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      accepted   = in_valid && !in_stall;
      // a stalled request stays up with the same payload
      next_valid = in_valid && !accepted;
      if (accepted) begin
        expected_roots.push_back(bisect_predict(in_data));
        sent_count++;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          // end of burst: mostly no gap, some short ones, a few long ones
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: gap_left = 0;
            5, 6, 7:       gap_left = $urandom_range(1, 8);
            default:       gap_left = $urandom_range(20, 400);
          endcase
          burst_left = $urandom_range(1, 6);
        end
      end
      if (!next_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_reqs.size() > 0) begin
          in_data    <= pending_reqs.pop_front();
          next_valid = 1'b1;
        end
      end
      in_valid <= next_valid;
    end
  end

  // ---------------------------------------------------------------------------
  // result monitor and receiver stall pattern
  // ---------------------------------------------------------------------------
  int unsigned stall_run  = 0;
  int unsigned mon_cycles = 0;

  always @(posedge clk) begin : check_results
    pbr_out_t want;
    logic     stall_next;
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_run  = 0;
      mon_cycles = 0;
    end else begin
      mon_cycles++;
      if (out_valid && !out_stall) begin
        if (expected_roots.size() == 0) begin
          note_fault($sformatf("result with nothing outstanding: %h", out_data));
        end else begin
          want = expected_roots.pop_front();
          checked_count++;
          if (want.status == ST_CONVERGED) conv_seen++;
          else if (want.status == ST_SIGN_ERR) sign_err_seen++;
          else limit_seen++;
          if (out_data.end_a !== want.end_a)
            note_fault($sformatf("result %0d end_a: expected %h, got %h",
                                 checked_count, want.end_a, out_data.end_a));
          if (out_data.end_b !== want.end_b)
            note_fault($sformatf("result %0d end_b: expected %h, got %h",
                                 checked_count, want.end_b, out_data.end_b));
          if (out_data.root_estimate !== want.root_estimate)
            note_fault($sformatf("result %0d root_estimate: expected %h, got %h",
                                 checked_count, want.root_estimate, out_data.root_estimate));
          if (out_data.status !== want.status)
            note_fault($sformatf("result %0d status: expected %0d, got %0d",
                                 checked_count, want.status, out_data.status));
          if (out_data.iterations_used !== want.iterations_used)
            note_fault($sformatf("result %0d iterations_used: expected %0d, got %0d",
                                 checked_count, want.iterations_used,
                                 out_data.iterations_used));
        end
      end
      // three stall modes, taken in turn: none, coin flip, long runs
      case ((mon_cycles >> 11) % 3)
        0: stall_next = 1'b0;
        1: stall_next = 1'($urandom_range(0, 1));
        default: begin
          if (stall_run > 0) begin
            stall_run--;
            stall_next = out_stall;
          end else begin
            stall_next = !out_stall;
            stall_run  = $urandom_range(1, 30);
          end
        end
      endcase
      out_stall <= stall_next;
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog
  // ---------------------------------------------------------------------------
  initial begin : watchdog
    while (cycle_count < RUN_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // stimulus: directed phases, then random register loads with their requests
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    pbr_in_t                   req;
    logic [VAL_W-1:0]          c [COEFF_COUNT];
    logic signed [VAL_W-1:0]   root, scale;
    logic signed [2*VAL_W-1:0] root_prod;
    logic [TOL_W-1:0]          tol;
    int unsigned               reach;
    logic                      found;
    for (int i = 0; i < COEFF_COUNT; i++) coef_shadow[i] = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset registers: f is zero everywhere, so every midpoint moves the first end
    queue_req('0, '0);
    queue_req(Q_MIN, Q_MAX);
    queue_req(Q_MAX, Q_MIN);

    // f(x) = x - 1.5
    load_setting(-32'sd98304, 32'sd65536, '0, '0, '0, '0, 16'd16, 8'd40);
    queue_req(32'sd0, 32'sd262144);          // bracket 0 .. 4.0
    queue_req(32'sd262144, 32'sd0);          // same, reversed
    queue_req(32'sd131072, 32'sd327680);     // both positive: sign error
    queue_req(-32'sd196608, -32'sd65536);    // both negative: sign error
    queue_req(32'sd98304, 32'sd196608);      // root on the first end
    queue_req(32'sd0, 32'sd196608);          // root at the first midpoint
    queue_req(Q_MIN, Q_MAX);

    // single iteration, widest tolerance
    load_setting(-32'sd98304, 32'sd65536, '0, '0, '0, '0, 16'hffff, 8'd1);
    queue_req(32'sd0, 32'sd262144);          // still too wide: limit
    queue_req(32'sd65536, 32'sd131072);      // narrow enough after one step
    queue_req(32'sd196608, 32'sd262144);     // sign error

    // tightest tolerance, longest limit: an interval of one lsb may never close
    load_setting(-32'sd98304, 32'sd65536, '0, '0, '0, '0, 16'd1, 8'hff);
    queue_req(32'sd65536, 32'sd131072);
    queue_req(32'sd131072, 32'sd65536);

    // extreme coefficients drive the power and the sum into saturation
    load_setting(Q_MIN, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MIN, RESET_TOL, 8'd30);
    queue_req(Q_MIN, Q_MAX);
    queue_req(Q_MAX, Q_MAX);
    queue_req(32'hffff_ffff, 32'h0000_0001);
    queue_req(32'h4000_0000, 32'hc000_0000);

    // random part: mostly intervals that bracket a sign change, some raw noise
    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      for (int i = 0; i < COEFF_COUNT; i++) c[i] = '0;
      case (poly_style_t'(phase % 3))
        POLY_MODERATE: begin
          // within +-4.0, higher terms often absent
          for (int i = 0; i < COEFF_COUNT; i++)
            if (i < 2 || $urandom_range(0, 2) != 0)
              c[i] = $urandom_range(0, 1 << 19) - (1 << 18);
        end
        POLY_FULL_RANGE: begin
          for (int i = 0; i < COEFF_COUNT; i++) c[i] = $urandom();
        end
        default: begin
          // s * (x - r) * (1 + x^2): one real root at r
          root  = $urandom_range(0, 1 << 21) - (1 << 20);
          scale = $urandom_range(1 << 14, 1 << 17);
          if ($urandom_range(0, 1) != 0) scale = -scale;
          root_prod = scale * root;
          c[0] = VAL_W'(-(root_prod >>> FRAC_BITS));
          c[1] = scale;
          c[2] = VAL_W'(-(root_prod >>> FRAC_BITS));
          c[3] = scale;
        end
      endcase
      tol = ($urandom_range(0, 3) == 0) ? TOL_W'($urandom_range(1, 65535))
                                         : TOL_W'($urandom_range(2, 300));
      load_setting(c[0], c[1], c[2], c[3], c[4], c[5], tol, ITER_W'($urandom_range(8, 60)));

      for (int n = 0; n < PHASE_REQS; n++) begin
        if ($urandom_range(0, 4) == 0) begin
          req.start_a = $urandom();
          req.start_b = $urandom();
        end else begin
          // search a window of random reach for ends of opposite sign
          reach = 1 << $urandom_range(14, 22);
          found = 1'b0;
          for (int k = 0; k < 16 && !found; k++) begin
            req.start_a = $urandom_range(0, 2 * reach) - reach;
            req.start_b = $urandom_range(0, 2 * reach) - reach;
            found = !same_sign(poly_value(req.start_a), poly_value(req.start_b));
          end
        end
        pending_reqs.push_back(req);
      end
    end

    drain_all();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d requests under %0d register configurations, %0d results checked",
             sent_count, config_count, checked_count);
    $display("outcomes: %0d converged, %0d same-sign errors, %0d at the iteration limit",
             conv_seen, sign_err_seen, limit_seen);
    if (fault_count == 0 && expected_roots.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
